[hdl/psm_pkg.sv]
// Shared types, constants and arithmetic helpers of the planar shadow matrix unit.
package psm_pkg;

    localparam int CoordW    = 32;
    localparam int AccW      = 66;
    localparam int MagW      = 64;
    localparam int PlW       = 18;
    localparam int RemW      = 50;
    localparam int QuotW     = 17;
    localparam int CntW      = 6;
    localparam int SqrtSteps = 32;
    localparam int NumPoints = 3;
    localparam int PtAddrW   = 2;

    localparam logic [1:0] SLOT_LIGHT = 2'd3;

    localparam logic [CntW-1:0] LOAD_END   = 6'd3;
    localparam logic [CntW-1:0] CROSS_END  = 6'd6;
    localparam logic [CntW-1:0] SQUARE_END = 6'd3;
    localparam logic [CntW-1:0] SQRT_END   = 6'(SqrtSteps - 1);
    localparam logic [CntW-1:0] DIV_END    = 6'd18;
    localparam logic [CntW-1:0] PLANE_END  = 6'd8;
    localparam logic [3:0]      LAST_ENTRY = 4'd15;
    localparam logic [1:0]      LAST_COMP  = 2'd2;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CROSS,
        ST_SHIFT,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_PLANE,
        ST_EMIT_MUL,
        ST_EMIT_OUT
    } state_t;

    function automatic coord_t sat_diff(input coord_t x, input coord_t y);
        logic signed [CoordW:0] d;
        d = {x[CoordW-1], x} - {y[CoordW-1], y};
        if (d[CoordW] != d[CoordW-1]) begin
            return d[CoordW] ? coord_t'({1'b1, {(CoordW-1){1'b0}}})
                             : coord_t'({1'b0, {(CoordW-1){1'b1}}});
        end
        return coord_t'(d[CoordW-1:0]);
    endfunction

    function automatic logic signed [49:0] round_q16(input logic signed [AccW-1:0] e);
        logic signed [AccW-1:0] t;
        t = e + 66'sd32768;
        return $signed(t[AccW-1:16]);
    endfunction

    function automatic coord_t sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return coord_t'(32'h7FFF_FFFF);
        end
        if (v < -50'sd2147483648) begin
            return coord_t'(32'h8000_0000);
        end
        return coord_t'(v[CoordW-1:0]);
    endfunction

endpackage

[hdl/planar_shadow_matrix_unit.sv]
// Planar shadow projection matrix unit built around one shared multiplier and a sequencer.
//
//  channel  | dir | tdata (lowest bit up)                     | tuser       | tlast
//  s_ item  | in  | coord_x, coord_y, coord_z, coord_w (128b) | slot (2b)   | -
//  m_ item  | out | row, column, entry_value, zero pad (40b)  | degenerate  | last_entry
//
// A point item is stored in the point memory and yields no output.
// A light item runs through row loads, six cross products, up to 33 normalizing shifts,
// 32 square root steps, three 17-step divisions and 16 entries through the shared
// 33 x 33 multiplier; a degenerate plane goes from the cross products straight to the entries.
// Reset is synchronous on aresetn low and clears the sequencer and the output valid.
// s_tready is low while a light item is in work; an output stall holds the sequencer.
module planar_shadow_matrix_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // coord_x, coord_y, coord_z, coord_w
    input  logic [1:0]   s_tuser,   // slot
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // row, column, entry_value, zero pad
    output logic         m_tuser,   // degenerate
    output logic         m_tlast
);

    psm_pkg::state_t state_reg, state_next;
    logic [psm_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;
    logic out_load, out_free, s_accept;

    logic [95:0] pt_mem [psm_pkg::NumPoints];
    logic [95:0] rd_row_reg;
    psm_pkg::coord_t row_pt [3];

    psm_pkg::coord_t lt_reg [4];
    psm_pkg::coord_t a_reg [3];
    psm_pkg::coord_t b_reg [3];
    psm_pkg::coord_t c_reg [3];
    logic [psm_pkg::MagW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic degen_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [psm_pkg::AccW-1:0] prod_reg, acc_reg, dot_reg;
    logic signed [psm_pkg::AccW-1:0] cross_val, acc_sum, entry_e;
    logic [psm_pkg::MagW-1:0] cross_mag;
    logic cross_degen, mag_big;

    logic [63:0] sq_v_reg, sq_res_reg, bit_reg, sq_trial;
    logic [psm_pkg::RemW-1:0] rem_reg, dsh_reg;
    logic [psm_pkg::QuotW-1:0] q_reg;
    logic signed [psm_pkg::PlW-1:0] pl_reg [3];
    logic signed [psm_pkg::PlW-1:0] pl_new;
    psm_pkg::coord_t pl3_reg, entry_val, pl_row;

    logic m_tvalid_reg, m_tuser_reg, m_tlast_reg;
    logic [39:0] m_tdata_reg;

    assign s_tready = (state_reg == psm_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign row_pt[0] = psm_pkg::coord_t'(rd_row_reg[31:0]);
    assign row_pt[1] = psm_pkg::coord_t'(rd_row_reg[63:32]);
    assign row_pt[2] = psm_pkg::coord_t'(rd_row_reg[95:64]);

    assign cross_val   = acc_reg - prod_reg;
    assign cross_mag   = cross_val[psm_pkg::AccW-1] ? psm_pkg::MagW'(-cross_val)
                                                    : cross_val[psm_pkg::MagW-1:0];
    assign cross_degen = (cross_mag == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
    assign mag_big     = (|mag_reg[0][63:31]) || (|mag_reg[1][63:31]) || (|mag_reg[2][63:31]);
    assign acc_sum     = acc_reg + prod_reg;
    assign sq_trial    = sq_res_reg + bit_reg;
    assign pl_new      = neg_reg[0] ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

    always_comb begin
        unique case (idx_reg[3:2])
            2'd0:    pl_row = psm_pkg::coord_t'(pl_reg[0]);
            2'd1:    pl_row = psm_pkg::coord_t'(pl_reg[1]);
            2'd2:    pl_row = psm_pkg::coord_t'(pl_reg[2]);
            default: pl_row = pl3_reg;
        endcase
        entry_e = ((idx_reg[3:2] == idx_reg[1:0]) ? dot_reg : '0) - prod_reg;
        entry_val = degen_reg ? '0 : psm_pkg::sat32(psm_pkg::round_q16(entry_e));
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            psm_pkg::ST_CROSS: begin
                unique case (cnt_reg)
                    6'd0: begin mul_a = 33'(a_reg[1]); mul_b = 33'(b_reg[2]); end
                    6'd1: begin mul_a = 33'(a_reg[2]); mul_b = 33'(b_reg[1]); end
                    6'd2: begin mul_a = 33'(a_reg[2]); mul_b = 33'(b_reg[0]); end
                    6'd3: begin mul_a = 33'(a_reg[0]); mul_b = 33'(b_reg[2]); end
                    6'd4: begin mul_a = 33'(a_reg[0]); mul_b = 33'(b_reg[1]); end
                    6'd5: begin mul_a = 33'(a_reg[1]); mul_b = 33'(b_reg[0]); end
                    default: ;
                endcase
            end
            psm_pkg::ST_SQUARE: begin
                unique case (cnt_reg)
                    6'd0: begin mul_a = {2'b0, mag_reg[0][30:0]}; mul_b = mul_a; end
                    6'd1: begin mul_a = {2'b0, mag_reg[1][30:0]}; mul_b = mul_a; end
                    6'd2: begin mul_a = {2'b0, mag_reg[2][30:0]}; mul_b = mul_a; end
                    default: ;
                endcase
            end
            psm_pkg::ST_PLANE: begin
                unique case (cnt_reg)
                    6'd0: begin mul_a = 33'(pl_reg[0]); mul_b = 33'(c_reg[0]); end
                    6'd1: begin mul_a = 33'(pl_reg[1]); mul_b = 33'(c_reg[1]); end
                    6'd2: begin mul_a = 33'(pl_reg[2]); mul_b = 33'(c_reg[2]); end
                    6'd4: begin mul_a = 33'(pl_reg[0]); mul_b = 33'(lt_reg[0]); end
                    6'd5: begin mul_a = 33'(pl_reg[1]); mul_b = 33'(lt_reg[1]); end
                    6'd6: begin mul_a = 33'(pl_reg[2]); mul_b = 33'(lt_reg[2]); end
                    6'd7: begin mul_a = 33'(pl3_reg);   mul_b = 33'(lt_reg[3]); end
                    default: ;
                endcase
            end
            psm_pkg::ST_EMIT_MUL, psm_pkg::ST_EMIT_OUT: begin
                mul_a = 33'(pl_row);
                mul_b = 33'(lt_reg[idx_reg[1:0]]);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        idx_next   = idx_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            psm_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_accept && (s_tuser == psm_pkg::SLOT_LIGHT)) begin
                    state_next = psm_pkg::ST_LOAD;
                end
            end
            psm_pkg::ST_LOAD: begin
                if (cnt_reg == psm_pkg::LOAD_END) begin
                    state_next = psm_pkg::ST_CROSS;
                    cnt_next   = '0;
                end
            end
            psm_pkg::ST_CROSS: begin
                if (cnt_reg == psm_pkg::CROSS_END) begin
                    state_next = cross_degen ? psm_pkg::ST_EMIT_MUL : psm_pkg::ST_SHIFT;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            psm_pkg::ST_SHIFT: begin
                cnt_next = '0;
                if (!mag_big) begin
                    state_next = psm_pkg::ST_SQUARE;
                end
            end
            psm_pkg::ST_SQUARE: begin
                if (cnt_reg == psm_pkg::SQUARE_END) begin
                    state_next = psm_pkg::ST_SQRT;
                    cnt_next   = '0;
                end
            end
            psm_pkg::ST_SQRT: begin
                if (cnt_reg == psm_pkg::SQRT_END) begin
                    state_next = psm_pkg::ST_DIV;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            psm_pkg::ST_DIV: begin
                if (cnt_reg == psm_pkg::DIV_END) begin
                    cnt_next = '0;
                    if (idx_reg[1:0] == psm_pkg::LAST_COMP) begin
                        state_next = psm_pkg::ST_PLANE;
                        idx_next   = '0;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            psm_pkg::ST_PLANE: begin
                if (cnt_reg == psm_pkg::PLANE_END) begin
                    state_next = psm_pkg::ST_EMIT_MUL;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            psm_pkg::ST_EMIT_MUL: begin
                state_next = psm_pkg::ST_EMIT_OUT;
                cnt_next   = '0;
            end
            psm_pkg::ST_EMIT_OUT: begin
                cnt_next = '0;
                if (out_free) begin
                    out_load = 1'b1;
                    if (idx_reg == psm_pkg::LAST_ENTRY) begin
                        state_next = psm_pkg::ST_IDLE;
                    end else begin
                        state_next = psm_pkg::ST_EMIT_MUL;
                        idx_next   = idx_reg + 4'd1;
                    end
                end
            end
            default: state_next = psm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psm_pkg::ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (s_tuser != psm_pkg::SLOT_LIGHT)) begin
            pt_mem[s_tuser] <= s_tdata[95:0];
        end
        if ((state_reg == psm_pkg::ST_LOAD) && (cnt_reg < 6'(psm_pkg::NumPoints))) begin
            rd_row_reg <= pt_mem[cnt_reg[psm_pkg::PtAddrW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (out_load) begin
            m_tdata_reg <= {4'b0, entry_val, idx_reg[1:0], idx_reg[3:2]};
            m_tuser_reg <= degen_reg;
            m_tlast_reg <= (idx_reg == psm_pkg::LAST_ENTRY);
        end
        unique case (state_reg)
            psm_pkg::ST_IDLE: begin
                if (s_accept && (s_tuser == psm_pkg::SLOT_LIGHT)) begin
                    lt_reg[0] <= psm_pkg::coord_t'(s_tdata[31:0]);
                    lt_reg[1] <= psm_pkg::coord_t'(s_tdata[63:32]);
                    lt_reg[2] <= psm_pkg::coord_t'(s_tdata[95:64]);
                    lt_reg[3] <= psm_pkg::coord_t'(s_tdata[127:96]);
                end
            end
            psm_pkg::ST_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    if (cnt_reg == 6'd1) begin
                        a_reg[i] <= row_pt[i];
                    end else if (cnt_reg == 6'd2) begin
                        a_reg[i] <= psm_pkg::sat_diff(a_reg[i], row_pt[i]);
                        b_reg[i] <= row_pt[i];
                    end else if (cnt_reg == 6'd3) begin
                        b_reg[i] <= psm_pkg::sat_diff(b_reg[i], row_pt[i]);
                        c_reg[i] <= row_pt[i];
                    end
                end
            end
            psm_pkg::ST_CROSS: begin
                if (cnt_reg != '0) begin
                    if (cnt_reg[0]) begin
                        acc_reg <= prod_reg;
                    end else begin
                        mag_reg[0] <= mag_reg[1];
                        mag_reg[1] <= mag_reg[2];
                        mag_reg[2] <= cross_mag;
                        neg_reg[0] <= neg_reg[1];
                        neg_reg[1] <= neg_reg[2];
                        neg_reg[2] <= cross_val[psm_pkg::AccW-1];
                    end
                end
                if (cnt_reg == psm_pkg::CROSS_END) begin
                    degen_reg <= cross_degen;
                end
            end
            psm_pkg::ST_SHIFT: begin
                if (mag_big) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
            end
            psm_pkg::ST_SQUARE: begin
                if (cnt_reg == 6'd1) begin
                    acc_reg <= prod_reg;
                end else if (cnt_reg != '0) begin
                    acc_reg <= acc_sum;
                end
                if (cnt_reg == psm_pkg::SQUARE_END) begin
                    sq_v_reg   <= acc_sum[63:0];
                    sq_res_reg <= '0;
                    bit_reg    <= 64'h4000_0000_0000_0000;
                end
            end
            psm_pkg::ST_SQRT: begin
                if (sq_v_reg >= sq_trial) begin
                    sq_v_reg   <= sq_v_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            psm_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    rem_reg <= psm_pkg::RemW'({mag_reg[0][30:0], 17'b0})
                             + psm_pkg::RemW'(sq_res_reg[31:0]);
                    dsh_reg <= {1'b0, sq_res_reg[31:0], 17'b0};
                    q_reg   <= '0;
                end else if (cnt_reg == psm_pkg::DIV_END) begin
                    pl_reg[0]  <= pl_reg[1];
                    pl_reg[1]  <= pl_reg[2];
                    pl_reg[2]  <= pl_new;
                    mag_reg[0] <= mag_reg[1];
                    mag_reg[1] <= mag_reg[2];
                    mag_reg[2] <= mag_reg[0];
                    neg_reg[0] <= neg_reg[1];
                    neg_reg[1] <= neg_reg[2];
                    neg_reg[2] <= neg_reg[0];
                end else begin
                    if (rem_reg >= dsh_reg) begin
                        rem_reg <= rem_reg - dsh_reg;
                        q_reg   <= {q_reg[psm_pkg::QuotW-2:0], 1'b1};
                    end else begin
                        q_reg   <= {q_reg[psm_pkg::QuotW-2:0], 1'b0};
                    end
                    dsh_reg <= dsh_reg >> 1;
                end
            end
            psm_pkg::ST_PLANE: begin
                if ((cnt_reg == 6'd1) || (cnt_reg == 6'd5)) begin
                    acc_reg <= prod_reg;
                end else if ((cnt_reg == 6'd2) || (cnt_reg == 6'd6) || (cnt_reg == 6'd7)) begin
                    acc_reg <= acc_sum;
                end else if (cnt_reg == 6'd3) begin
                    pl3_reg <= psm_pkg::sat32(-psm_pkg::round_q16(acc_sum));
                end else if (cnt_reg == psm_pkg::PLANE_END) begin
                    dot_reg <= acc_sum;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_last_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[3:0] == 4'hF)
        else $error("last entry is not at row 3, column 3");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[35:4] == 32'h0)
        else $error("degenerate entry carries a nonzero value");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == psm_pkg::ST_DIV |-> sq_res_reg[31:0] != 32'h0)
        else $error("division entered with zero normal length");

    a_mag_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == psm_pkg::ST_SQUARE |-> !mag_big)
        else $error("squares taken before normalizing shift finished");

    a_busy_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == psm_pkg::SLOT_LIGHT |=> !s_tready)
        else $error("input still ready after a light item");
`endif

endmodule
